/* rtl/ppo_pkg.sv */
// Package for the ping-pong oscillator offset block: payload types, codes, sine table math.
package ppo_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int QUO_W      = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TOP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_BOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 3'd6;

  localparam logic OP_APPLY = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  localparam logic [15:0] PERIOD_RST    = 16'd180;
  localparam logic [15:0] POSITION_RST  = 16'd90;
  localparam logic [19:0] AMPLITUDE_RST = 20'd8192;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef struct packed {
    logic               op;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
  } ppo_in_t;

  typedef struct packed {
    logic signed [23:0] moved_x;
    logic signed [23:0] moved_y;
    logic signed [15:0] wave_value;
  } ppo_out_t;

  // Q2.30 cosine over [0, pi/2], clamped to [0, 1]
  function automatic logic [63:0] cos_q30(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    sum  = $signed(ONE_Q30);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (sum > $signed(ONE_Q30)) begin
      sum = $signed(ONE_Q30);
    end
    return $unsigned(sum);
  endfunction

endpackage

/* rtl/ping_pong_oscillator_offset.sv */
// Ping-pong oscillator offset block: sweep counter, shared divider, sine lookup, offset.
// Tick request: accepted while idle, updates the sweep and returns no result.
// Apply request: restoring divider, then lookup, shaping, multiply and output stages;
// the result is registered once the output is free; next request taken once it is loaded.
// The divider's one quotient bit per cycle sets the apply rate; one apply is in flight at a time.
// Synchronous reset loads register defaults, position 90 rising; the sine ROM is constant.
module ping_pong_oscillator_offset #(
  parameter int SINE_TABLE_BITS = ppo_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ppo_pkg::ppo_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ppo_pkg::ppo_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppo_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int TBL_N = 1 << SINE_TABLE_BITS;
  localparam int IDX_W = SINE_TABLE_BITS + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_LOOK = 3'd2;
  localparam logic [2:0] ST_FORM = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  typedef logic signed [16:0] rom_t [0:TBL_N];

  function automatic rom_t gen_rom();
    rom_t        r;
    logic [63:0] x;
    logic [63:0] c;
    int          u;
    for (int i = 0; i <= TBL_N; i++) begin
      u = (i <= TBL_N / 2) ? i : TBL_N - i;
      x = (ppo_pkg::PI_Q30 * 64'(u)) >> SINE_TABLE_BITS;
      c = (ppo_pkg::cos_q30(x) + 64'd16384) >> 15;
      r[i] = (i <= TBL_N / 2) ? -$signed(c[16:0]) : $signed(c[16:0]);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = gen_rom();

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    if (v > 25'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -25'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  logic [2:0]  state_r;
  logic [15:0] period_r;
  logic [15:0] dwell_top_r;
  logic [15:0] dwell_bot_r;
  logic        linear_r;
  logic        invert_r;
  logic [1:0]  axis_r;
  logic [19:0] amp_r;

  logic [15:0] pos_r, pos_nxt;
  logic        rising_r, rising_nxt;
  logic [15:0] dwell_r, dwell_nxt;

  logic signed [23:0] px_r;
  logic signed [23:0] py_r;
  logic [17:0]        rem_r;
  logic [16:0]        lo_r;
  logic [16:0]        quo_r;
  logic [16:0]        div_v_r;
  logic [4:0]         cnt_r;
  logic signed [16:0] rom_q_r;
  logic signed [15:0] wave_r;
  logic signed [36:0] prod_r;

  logic              out_valid_r;
  ppo_pkg::ppo_out_t out_data_r;

  logic               in_fire;
  logic [16:0]        pos_inc;
  logic [15:0]        pos_c;
  logic [31:0]        dvd;
  logic [17:0]        rem_sh;
  logic [18:0]        diff;
  logic               ge;
  logic [IDX_W-1:0]   idx;
  logic signed [17:0] raw;
  logic signed [17:0] shaped;
  logic signed [15:0] wave_c;
  logic signed [36:0] prod_rnd;
  logic signed [21:0] delta;
  logic signed [24:0] sum_x;
  logic signed [24:0] sum_y;
  logic               out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    pos_inc    = {1'b0, pos_r} + 17'd1;
    pos_nxt    = pos_r;
    rising_nxt = rising_r;
    dwell_nxt  = dwell_r;
    if (dwell_r != 16'd0) begin
      dwell_nxt = dwell_r - 16'd1;
    end else if (rising_r) begin
      if (pos_inc >= {1'b0, period_r}) begin
        rising_nxt = 1'b0;
        pos_nxt    = period_r;
        dwell_nxt  = dwell_top_r;
      end else begin
        pos_nxt = pos_inc[15:0];
      end
    end else begin
      if (pos_r <= 16'd1) begin
        rising_nxt = 1'b1;
        pos_nxt    = 16'd0;
        dwell_nxt  = dwell_bot_r;
      end else begin
        pos_nxt = pos_r - 16'd1;
      end
    end
  end

  always_comb begin
    pos_c = (pos_r > period_r) ? period_r : pos_r;
    if (linear_r) begin
      dvd = {pos_c, 16'd0};
    end else begin
      dvd = (32'(pos_c) << (SINE_TABLE_BITS + 1)) + 32'(period_r);
    end
    rem_sh = {rem_r[16:0], lo_r[16]};
    diff   = {1'b0, rem_sh} - {2'b00, div_v_r};
    ge     = !diff[18];
    idx    = (quo_r > 17'(TBL_N)) ? IDX_W'(TBL_N) : quo_r[IDX_W-1:0];
  end

  always_comb begin
    if (period_r == 16'd0) begin
      raw = 18'sd0;
    end else if (linear_r) begin
      raw = $signed({1'b0, quo_r}) - 18'sd32768;
    end else begin
      raw = 18'(rom_q_r);
    end
    shaped = invert_r ? -raw : raw;
    if (shaped > 18'sd32767) begin
      wave_c = 16'sh7FFF;
    end else if (shaped < -18'sd32768) begin
      wave_c = 16'sh8000;
    end else begin
      wave_c = shaped[15:0];
    end
  end

  always_comb begin
    prod_rnd = prod_r + 37'sd16384;
    delta    = prod_rnd[36:15];
    sum_x    = 25'(px_r) + 25'(delta);
    sum_y    = 25'(py_r) + 25'(delta);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= ppo_pkg::PERIOD_RST;
      dwell_top_r <= 16'd0;
      dwell_bot_r <= 16'd0;
      linear_r    <= 1'b0;
      invert_r    <= 1'b0;
      axis_r      <= ppo_pkg::AXIS_X;
      amp_r       <= ppo_pkg::AMPLITUDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppo_pkg::CFG_PERIOD:    period_r    <= cfg_data[15:0];
        ppo_pkg::CFG_DWELL_TOP: dwell_top_r <= cfg_data[15:0];
        ppo_pkg::CFG_DWELL_BOT: dwell_bot_r <= cfg_data[15:0];
        ppo_pkg::CFG_LINEAR:    linear_r    <= cfg_data[0];
        ppo_pkg::CFG_INVERT:    invert_r    <= cfg_data[0];
        ppo_pkg::CFG_AXIS:      axis_r      <= cfg_data[1:0];
        ppo_pkg::CFG_AMPLITUDE: amp_r       <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= ppo_pkg::POSITION_RST;
      rising_r <= 1'b1;
      dwell_r  <= 16'd0;
    end else if (in_fire && in_data.op == ppo_pkg::OP_TICK) begin
      pos_r    <= pos_nxt;
      rising_r <= rising_nxt;
      dwell_r  <= dwell_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire && in_data.op == ppo_pkg::OP_APPLY) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt_r == 5'(ppo_pkg::QUO_W - 1)) begin
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: state_r <= ST_FORM;
        ST_FORM: state_r <= ST_MUL;
        ST_MUL:  state_r <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        px_r    <= in_data.point_x;
        py_r    <= in_data.point_y;
        rem_r   <= 18'(dvd[31:17]);
        lo_r    <= dvd[16:0];
        div_v_r <= linear_r ? {1'b0, period_r} : {period_r, 1'b0};
        cnt_r   <= 5'd0;
      end
      ST_DIV: begin
        rem_r <= ge ? diff[17:0] : rem_sh;
        lo_r  <= {lo_r[15:0], 1'b0};
        quo_r <= {quo_r[15:0], ge};
        cnt_r <= cnt_r + 5'd1;
      end
      ST_LOOK: rom_q_r <= SINE_ROM[idx];
      ST_FORM: wave_r  <= wave_c;
      ST_MUL:  prod_r  <= wave_r * $signed({1'b0, amp_r});
      ST_DONE: begin
        if (out_free) begin
          out_data_r.moved_x    <= (axis_r != ppo_pkg::AXIS_Y) ? sat24(sum_x) : px_r;
          out_data_r.moved_y    <= (axis_r != ppo_pkg::AXIS_X) ? sat24(sum_y) : py_r;
          out_data_r.wave_value <= wave_r;
        end
      end
      default: ;
    endcase
  end

  a_apply_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.op == ppo_pkg::OP_APPLY) |=> (state_r == ST_DIV))
    else $error("apply request did not start the divider");

  a_dwell_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.op == ppo_pkg::OP_TICK && dwell_r != 16'd0) |=>
      ($stable(pos_r) && $stable(rising_r) && dwell_r == $past(dwell_r) - 16'd1))
    else $error("dwell tick moved the sweep");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < 5'(ppo_pkg::QUO_W)))
    else $error("divider step count overran");

endmodule

/* bench/ping_pong_oscillator_offset_test.sv */
// Testbench for the ping-pong oscillator offset block: directed, random and stalled traffic.
module ping_pong_oscillator_offset_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int              TBL_BITS    = ppo_pkg::SINE_TABLE_BITS_DEF;
  localparam int              TBL_N       = 1 << TBL_BITS;
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint          ONE_Q30     = 64'sd1073741824;
  localparam int              CYCLE_LIMIT = 500000;
  localparam int              SETTLE      = 40;

  localparam logic [ppo_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [1:0] AXIS_BOTH  = 2'd2;
  localparam logic [1:0] AXIS_SPARE = 2'd3;

  localparam logic signed [23:0] MAX_C = 24'sh7FFFFF;
  localparam logic signed [23:0] MIN_C = 24'sh800000;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  ppo_pkg::ppo_in_t               in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  ppo_pkg::ppo_out_t              out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ppo_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ppo_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic [15:0] period_q    = ppo_pkg::PERIOD_RST;
  logic [15:0] dwell_top_q = '0;
  logic [15:0] dwell_bot_q = '0;
  logic        linear_q    = 1'b0;
  logic        invert_q    = 1'b0;
  logic [1:0]  axis_q      = ppo_pkg::AXIS_X;
  logic [19:0] amplitude_q = ppo_pkg::AMPLITUDE_RST;
  logic [15:0] sweep_pos   = ppo_pkg::POSITION_RST;
  logic        rising_q    = 1'b1;
  logic [15:0] dwell_q     = '0;

  int                cos_table [0:TBL_N];
  ppo_pkg::ppo_out_t moved_points_q [$];

  int errors        = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles  = 0;

  ping_pong_oscillator_offset dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint unsigned cos_series(input longint unsigned ang);
    longint unsigned ang2;
    longint unsigned term;
    longint unsigned div;
    longint          acc;
    ang2 = (ang * ang) >> 30;
    term = ONE_Q30;
    acc  = ONE_Q30;
    for (int k = 1; k <= 8; k++) begin
      div  = (2 * k - 1) * (2 * k);
      term = ((term * ang2) >> 30) / div;
      if (k % 2 == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > ONE_Q30) begin
      acc = ONE_Q30;
    end
    return acc;
  endfunction

  function automatic longint clamp24(input longint v);
    if (v > 64'sd8388607) begin
      return 64'sd8388607;
    end
    if (v < -64'sd8388608) begin
      return -64'sd8388608;
    end
    return v;
  endfunction

  function automatic logic signed [15:0] wave_level();
    longint unsigned pos;
    longint unsigned per;
    longint unsigned idx;
    longint          v;
    pos = sweep_pos;
    per = period_q;
    if (per == 0) begin
      v = 0;
    end else begin
      if (pos > per) begin
        pos = per;
      end
      if (linear_q) begin
        v = longint'((pos << 16) / per) - 32768;
      end else begin
        idx = ((pos << (TBL_BITS + 1)) + per) / (2 * per);
        if (idx > TBL_N) begin
          idx = TBL_N;
        end
        v = cos_table[idx];
      end
      if (invert_q) begin
        v = -v;
      end
    end
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return v[15:0];
  endfunction

  function automatic ppo_pkg::ppo_out_t offset_point(input ppo_pkg::ppo_in_t req);
    ppo_pkg::ppo_out_t r;
    longint            w;
    longint            d;
    longint            x;
    longint            y;
    w = wave_level();
    d = (w * longint'(amplitude_q) + 64'sd16384) >>> 15;
    x = req.point_x;
    y = req.point_y;
    if (axis_q != ppo_pkg::AXIS_Y) begin
      x = clamp24(x + d);
    end
    if (axis_q != ppo_pkg::AXIS_X) begin
      y = clamp24(y + d);
    end
    r.moved_x    = x[23:0];
    r.moved_y    = y[23:0];
    r.wave_value = w[15:0];
    return r;
  endfunction

  function automatic void advance_sweep();
    if (dwell_q != 0) begin
      dwell_q--;
    end else if (rising_q) begin
      if ({1'b0, sweep_pos} + 17'd1 >= {1'b0, period_q}) begin
        rising_q  = 1'b0;
        sweep_pos = period_q;
        dwell_q   = dwell_top_q;
      end else begin
        sweep_pos++;
      end
    end else if (sweep_pos <= 16'd1) begin
      rising_q  = 1'b1;
      sweep_pos = '0;
      dwell_q   = dwell_bot_q;
    end else begin
      sweep_pos--;
    end
  endfunction

  function automatic logic signed [23:0] rand_coord();
    if ($urandom_range(7) == 0) begin
      return $urandom_range(1) ? MAX_C : MIN_C;
    end
    return 24'($urandom);
  endfunction

  function automatic ppo_pkg::ppo_in_t make_request(input int tick_pct);
    ppo_pkg::ppo_in_t req;
    req.op      = ($urandom_range(99) < tick_pct) ? ppo_pkg::OP_TICK : ppo_pkg::OP_APPLY;
    req.point_x = rand_coord();
    req.point_y = rand_coord();
    return req;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : result_check
    ppo_pkg::ppo_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (moved_points_q.size() == 0) begin
        report_mismatch("result with no request pending", out_data.moved_x, 0);
      end else begin
        want = moved_points_q.pop_front();
        if (out_data.moved_x !== want.moved_x) begin
          report_mismatch("moved_x", out_data.moved_x, want.moved_x);
        end
        if (out_data.moved_y !== want.moved_y) begin
          report_mismatch("moved_y", out_data.moved_y, want.moved_y);
        end
        if (out_data.wave_value !== want.wave_value) begin
          report_mismatch("wave_value", out_data.wave_value, want.wave_value);
        end
      end
    end
    if (stall_cycles > 0) begin
      out_ready <= 1'b0;
      stall_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input ppo_pkg::ppo_in_t req);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (req.op == ppo_pkg::OP_TICK) begin
      advance_sweep();
    end else begin
      moved_points_q.push_back(offset_point(req));
    end
  endtask

  task automatic apply_at(input logic signed [23:0] x, input logic signed [23:0] y);
    send_item('{op: ppo_pkg::OP_APPLY, point_x: x, point_y: y});
  endtask

  task automatic tick_once();
    send_item('{op: ppo_pkg::OP_TICK, point_x: rand_coord(), point_y: rand_coord()});
  endtask

  // drop the request line, then let the block go quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (moved_points_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ppo_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ppo_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ppo_pkg::CFG_PERIOD:    period_q    = val[15:0];
      ppo_pkg::CFG_DWELL_TOP: dwell_top_q = val[15:0];
      ppo_pkg::CFG_DWELL_BOT: dwell_bot_q = val[15:0];
      ppo_pkg::CFG_LINEAR:    linear_q    = val[0];
      ppo_pkg::CFG_INVERT:    invert_q    = val[0];
      ppo_pkg::CFG_AXIS:      axis_q      = val[1:0];
      ppo_pkg::CFG_AMPLITUDE: amplitude_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic randomize_config();
    logic [ppo_pkg::CFG_DATA_W-1:0] per;
    logic [ppo_pkg::CFG_DATA_W-1:0] amp;
    wait_idle();
    case ($urandom_range(7))
      0:       per = '0;
      1:       per = 20'hFFFF;
      2:       per = 20'($urandom_range(25, 300));
      default: per = 20'($urandom_range(1, 24));
    endcase
    case ($urandom_range(5))
      0:       amp = '0;
      1:       amp = 20'hFFFFF;
      default: amp = 20'($urandom);
    endcase
    write_reg(ppo_pkg::CFG_PERIOD, per);
    write_reg(ppo_pkg::CFG_DWELL_TOP, 20'($urandom_range(0, 3)));
    write_reg(ppo_pkg::CFG_DWELL_BOT, 20'($urandom_range(0, 3)));
    write_reg(ppo_pkg::CFG_LINEAR, 20'($urandom_range(1)));
    write_reg(ppo_pkg::CFG_INVERT, 20'($urandom_range(1)));
    write_reg(ppo_pkg::CFG_AXIS, 20'($urandom_range(3)));
    write_reg(ppo_pkg::CFG_AMPLITUDE, amp);
  endtask

  task automatic test_special_cases();
    apply_at(MAX_C, MIN_C);
    tick_once();
    wait_idle();
    write_reg(ppo_pkg::CFG_PERIOD, 20'd2);
    write_reg(ppo_pkg::CFG_AMPLITUDE, 20'hFFFFF);
    write_reg(ppo_pkg::CFG_AXIS, 20'(AXIS_BOTH));
    apply_at(MAX_C, MIN_C);
    tick_once();
    apply_at(MIN_C, MAX_C);
    tick_once();
    apply_at(24'sd0, 24'sd0);
    tick_once();
    apply_at(-24'sd1, -24'sd1);
    wait_idle();
    write_reg(ppo_pkg::CFG_DWELL_TOP, 20'd1);
    write_reg(ppo_pkg::CFG_DWELL_BOT, 20'd1);
    write_reg(ppo_pkg::CFG_LINEAR, 20'd1);
    write_reg(ppo_pkg::CFG_INVERT, 20'd1);
    write_reg(ppo_pkg::CFG_AXIS, 20'(ppo_pkg::AXIS_Y));
    apply_at(MAX_C, MAX_C);
    repeat (3) tick_once();
    apply_at(MIN_C, MIN_C);
    wait_idle();
    write_reg(ppo_pkg::CFG_PERIOD, 20'd0);
    write_reg(ppo_pkg::CFG_INVERT, 20'd0);
    write_reg(ppo_pkg::CFG_AXIS, 20'(AXIS_SPARE));
    apply_at(rand_coord(), rand_coord());
    repeat (4) tick_once();
    wait_idle();
    write_reg(ppo_pkg::CFG_INVERT, 20'hFFFFF);
    apply_at(rand_coord(), rand_coord());
    wait_idle();
    write_reg(CFG_UNUSED, 20'hFFFFF);
    write_reg(ppo_pkg::CFG_PERIOD, 20'hFFFFF);
    write_reg(ppo_pkg::CFG_DWELL_TOP, 20'hFFFFF);
    write_reg(ppo_pkg::CFG_DWELL_TOP, 20'd0);
    write_reg(ppo_pkg::CFG_DWELL_BOT, 20'hFFFFF);
    write_reg(ppo_pkg::CFG_DWELL_BOT, 20'd0);
    write_reg(ppo_pkg::CFG_LINEAR, 20'hFFFFE);
    write_reg(ppo_pkg::CFG_AMPLITUDE, 20'd0);
    write_reg(ppo_pkg::CFG_AXIS, 20'(ppo_pkg::AXIS_X));
    apply_at(rand_coord(), rand_coord());
    tick_once();
    apply_at(rand_coord(), rand_coord());
  endtask

  task automatic test_random_traffic(input int count);
    randomize_config();
    repeat (count) send_item(make_request(55));
  endtask

  // hold the result side while requests keep coming
  task automatic test_output_stall();
    stall_cycles = 300;
    repeat (40) send_item(make_request(20));
  endtask

  initial begin
    longint unsigned fold;
    longint unsigned c;
    for (int i = 0; i <= TBL_N; i++) begin
      fold = (i <= TBL_N / 2) ? i : TBL_N - i;
      c    = (cos_series((PI_Q30 * fold) / TBL_N) + 64'd16384) >> 15;
      cos_table[i] = (i <= TBL_N / 2) ? -int'(c) : int'(c);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 74;
    test_special_cases();
    test_random_traffic(170);
    test_output_stall();
    test_random_traffic(170);

    send_idle_pct = 74;
    recv_idle_pct = 33;
    test_random_traffic(170);
    test_random_traffic(170);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(170);
    test_random_traffic(170);

    wait_idle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* ping_pong_oscillator_offset.f */
rtl/ppo_pkg.sv
rtl/ping_pong_oscillator_offset.sv
bench/ping_pong_oscillator_offset_test.sv
